/* hw/rtl/assert_macros.svh */
// assertion macros for the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/yrgb_pkg.sv */
// constants for the bt.601 ycbcr to rgba converter
`default_nettype none

package yrgb_pkg;

  localparam int unsigned DATA_W            = 8;
  localparam int unsigned CHROMA_W          = DATA_W + 1;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  localparam logic [DATA_W-1:0] CHROMA_OFFSET = 8'd128;
  localparam logic [DATA_W-1:0] LUMA_MIN      = 8'd16;
  localparam logic [DATA_W-1:0] LUMA_MAX      = 8'd235;
  localparam logic [DATA_W-1:0] ALPHA_OPAQUE  = 8'd255;
  localparam logic [DATA_W-1:0] CHAN_MAX      = 8'd255;

  // luma stretch table, indexed by clamped luma minus the black level
  localparam int unsigned LUMA_TAB_DEPTH = 256;
  localparam int unsigned LUMA_SPAN      = 219;
  localparam int unsigned CHROMA_SPAN    = 224;
  localparam int unsigned FULL_SPAN      = 255;

  // matrix coefficients as exact ratios
  localparam longint unsigned KR_NUM  = 64'd1402;
  localparam longint unsigned KR_DEN  = 64'd1000;
  localparam longint unsigned KGU_NUM = 64'd344136;
  localparam longint unsigned KGU_DEN = 64'd1000000;
  localparam longint unsigned KGV_NUM = 64'd714136;
  localparam longint unsigned KGV_DEN = 64'd1000000;
  localparam longint unsigned KB_NUM  = 64'd1772;
  localparam longint unsigned KB_DEN  = 64'd1000;

endpackage

`default_nettype wire

/* hw/rtl/yrgb_sat.sv */
// rounding and saturation of one colour channel sum to a byte
`default_nettype none

module yrgb_sat #(
  parameter int unsigned FRAC_BITS = yrgb_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned SUM_W     = FRAC_BITS + 12
) (
  input  wire logic signed [SUM_W-1:0]            sum,
  output logic             [yrgb_pkg::DATA_W-1:0] chan
);

  localparam longint SAT_HIGH_L = longint'(yrgb_pkg::CHAN_MAX) <<< FRAC_BITS;
  localparam longint HALF_L     = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(SAT_HIGH_L);
  localparam logic signed [SUM_W-1:0] HALF     = SUM_W'(HALF_L);

  logic signed [SUM_W-1:0] rounded;

  assign rounded = sum + HALF;

  always_comb begin
    if (sum <= SUM_W'(0)) begin
      chan = '0;
    end else if (sum >= SAT_HIGH) begin
      chan = yrgb_pkg::CHAN_MAX;
    end else begin
      chan = rounded[FRAC_BITS +: yrgb_pkg::DATA_W];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ycbcr_to_rgba_bt601.sv */
// Converts one YCbCr pixel to RGBA with BT.601 coefficients in a four-stage
// pipeline: input register with luma clamp, coefficient multiply, channel sum,
// then round and saturate into the output register. One pixel is taken per
// clock unless stalled and passes the input, product, sum and output registers
// in turn. A per-stage ready chain joins the stages, so a stalled output backs
// up only as far as the first empty stage. full_swing selects full-range input
// (1, reset) or limited-range input (0), where luma is clamped to 16..235 and
// stretched and the chroma excursions are scaled by 255/224. Alpha is always
// 255. The range setting should be written only while no pixel is in flight.
`default_nettype none

`include "assert_macros.svh"

module ycbcr_to_rgba_bt601 #(
  parameter int unsigned FRAC_BITS = yrgb_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [yrgb_pkg::DATA_W-1:0]   luma,
  input  wire logic [yrgb_pkg::DATA_W-1:0]   chroma_blue,
  input  wire logic [yrgb_pkg::DATA_W-1:0]   chroma_red,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [yrgb_pkg::DATA_W-1:0]   red,
  output logic      [yrgb_pkg::DATA_W-1:0]   green,
  output logic      [yrgb_pkg::DATA_W-1:0]   blue,
  output logic      [yrgb_pkg::DATA_W-1:0]   alpha
);

  localparam int unsigned DW   = yrgb_pkg::DATA_W;
  localparam int unsigned CHW  = yrgb_pkg::CHROMA_W;
  localparam int unsigned CW   = FRAC_BITS + 2;
  localparam int unsigned YW   = FRAC_BITS + DW;
  localparam int unsigned SW   = FRAC_BITS + 12;
  localparam int unsigned TABW = $clog2(yrgb_pkg::LUMA_TAB_DEPTH);

  localparam longint unsigned FS = yrgb_pkg::FULL_SPAN;
  localparam longint unsigned CS = yrgb_pkg::CHROMA_SPAN;

  // coefficients rounded half up at FRAC_BITS
  localparam logic [CW-1:0] KR_F = CW'(((yrgb_pkg::KR_NUM << FRAC_BITS)
                                        + yrgb_pkg::KR_DEN / 2) / yrgb_pkg::KR_DEN);
  localparam logic [CW-1:0] KGU_F = CW'(((yrgb_pkg::KGU_NUM << FRAC_BITS)
                                         + yrgb_pkg::KGU_DEN / 2) / yrgb_pkg::KGU_DEN);
  localparam logic [CW-1:0] KGV_F = CW'(((yrgb_pkg::KGV_NUM << FRAC_BITS)
                                         + yrgb_pkg::KGV_DEN / 2) / yrgb_pkg::KGV_DEN);
  localparam logic [CW-1:0] KB_F = CW'(((yrgb_pkg::KB_NUM << FRAC_BITS)
                                        + yrgb_pkg::KB_DEN / 2) / yrgb_pkg::KB_DEN);

  localparam logic [CW-1:0] KR_L = CW'((((yrgb_pkg::KR_NUM * FS) << FRAC_BITS)
                                        + yrgb_pkg::KR_DEN * CS / 2)
                                       / (yrgb_pkg::KR_DEN * CS));
  localparam logic [CW-1:0] KGU_L = CW'((((yrgb_pkg::KGU_NUM * FS) << FRAC_BITS)
                                         + yrgb_pkg::KGU_DEN * CS / 2)
                                        / (yrgb_pkg::KGU_DEN * CS));
  localparam logic [CW-1:0] KGV_L = CW'((((yrgb_pkg::KGV_NUM * FS) << FRAC_BITS)
                                         + yrgb_pkg::KGV_DEN * CS / 2)
                                        / (yrgb_pkg::KGV_DEN * CS));
  localparam logic [CW-1:0] KB_L = CW'((((yrgb_pkg::KB_NUM * FS) << FRAC_BITS)
                                        + yrgb_pkg::KB_DEN * CS / 2)
                                       / (yrgb_pkg::KB_DEN * CS));

  // configuration
  logic full_swing;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_swing <= 1'b1;
    end else if (cfg_we) begin
      full_swing <= cfg_data;
    end
  end

  // limited-range luma stretch table
  logic [YW-1:0] luma_tab [yrgb_pkg::LUMA_TAB_DEPTH];

  for (genvar gi = 0; gi < yrgb_pkg::LUMA_TAB_DEPTH; gi++) begin : g_luma_tab
    localparam longint unsigned N = (gi > yrgb_pkg::LUMA_SPAN) ?
                                    longint'(yrgb_pkg::LUMA_SPAN) : longint'(gi);
    assign luma_tab[gi] = YW'((((N * FS) << FRAC_BITS) + yrgb_pkg::LUMA_SPAN / 2)
                              / yrgb_pkg::LUMA_SPAN);
  end

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic s1_valid, s2_valid, s3_valid;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // stage 1: input register, luma clamp in limited range
  logic [DW-1:0]         luma_clamped;
  logic [DW-1:0]         luma_in;
  logic                  s1_full;
  logic [DW-1:0]         s1_luma;
  logic signed [CHW-1:0] s1_cb;
  logic signed [CHW-1:0] s1_cr;

  always_comb begin
    if (luma < yrgb_pkg::LUMA_MIN) begin
      luma_clamped = yrgb_pkg::LUMA_MIN;
    end else if (luma > yrgb_pkg::LUMA_MAX) begin
      luma_clamped = yrgb_pkg::LUMA_MAX;
    end else begin
      luma_clamped = luma;
    end
    luma_in = full_swing ? luma : (luma_clamped - yrgb_pkg::LUMA_MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_full <= full_swing;
      s1_luma <= luma_in;
      s1_cb   <= signed'({1'b0, chroma_blue}) - signed'({1'b0, yrgb_pkg::CHROMA_OFFSET});
      s1_cr   <= signed'({1'b0, chroma_red}) - signed'({1'b0, yrgb_pkg::CHROMA_OFFSET});
    end
  end

  // stage 2: scaled luma and the four chroma products
  logic [CW-1:0]        kr, kgu, kgv, kb;
  logic [YW-1:0]        ys_next;
  logic [YW-1:0]        s2_ys;
  logic signed [SW-1:0] s2_pr, s2_pgu, s2_pgv, s2_pb;

  always_comb begin
    kr      = s1_full ? KR_F  : KR_L;
    kgu     = s1_full ? KGU_F : KGU_L;
    kgv     = s1_full ? KGV_F : KGV_L;
    kb      = s1_full ? KB_F  : KB_L;
    ys_next = s1_full ? {s1_luma, {FRAC_BITS{1'b0}}} : luma_tab[s1_luma[TABW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ys  <= ys_next;
      s2_pr  <= SW'(signed'({1'b0, kr}))  * SW'(s1_cr);
      s2_pgu <= SW'(signed'({1'b0, kgu})) * SW'(s1_cb);
      s2_pgv <= SW'(signed'({1'b0, kgv})) * SW'(s1_cr);
      s2_pb  <= SW'(signed'({1'b0, kb}))  * SW'(s1_cb);
    end
  end

  // stage 3: channel sums
  logic signed [SW-1:0] ys_ext;
  logic signed [SW-1:0] s3_r, s3_g, s3_b;

  assign ys_ext = signed'(SW'(s2_ys));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r <= ys_ext + s2_pr;
      s3_g <= ys_ext - s2_pgu - s2_pgv;
      s3_b <= ys_ext + s2_pb;
    end
  end

  // stage 4: round, saturate, output register
  logic [DW-1:0] red_next, green_next, blue_next;

  yrgb_sat #(.FRAC_BITS(FRAC_BITS), .SUM_W(SW)) u_sat_red (
    .sum  (s3_r),
    .chan (red_next)
  );

  yrgb_sat #(.FRAC_BITS(FRAC_BITS), .SUM_W(SW)) u_sat_green (
    .sum  (s3_g),
    .chan (green_next)
  );

  yrgb_sat #(.FRAC_BITS(FRAC_BITS), .SUM_W(SW)) u_sat_blue (
    .sum  (s3_b),
    .chan (blue_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign alpha = yrgb_pkg::ALPHA_OPAQUE;

  // back-pressure only when every stage holds a word
  `ASSERT_SAME(a_full_when_blocked, clk, rst, !in_ready,
               s1_valid && s2_valid && s3_valid && out_valid && !out_ready,
               "input blocked with an empty stage")

  `ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && in_ready, s1_valid,
               "accepted word missing from first stage")

  `ASSERT_NEXT(a_stage1_holds, clk, rst, s1_valid && !en2, s1_valid,
               "stalled first stage dropped its word")

  `ASSERT_NEXT(a_red_floor, clk, rst, s3_valid && en4 && s3_r <= SW'(0), red == '0,
               "negative red sum not saturated to zero")

endmodule

`default_nettype wire

/* tb/sv/ycbcr_to_rgba_bt601_test.sv */
// self-checking testbench for the bt.601 ycbcr to rgba converter
`default_nettype none

module ycbcr_to_rgba_bt601_test;

  localparam int unsigned DW         = yrgb_pkg::DATA_W;
  localparam int unsigned FRAC       = yrgb_pkg::FRAC_BITS_DEFAULT;
  localparam longint      ONE_FX     = longint'(1) << FRAC;
  localparam longint      HALF_FX    = ONE_FX >>> 1;
  localparam int unsigned LATENCY    = 4;
  localparam int unsigned CYCLE_MAX  = 500000;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_PIXS = 110;
  localparam int unsigned CASE_COUNT = 24;

  typedef struct packed {
    logic [DW-1:0] red;
    logic [DW-1:0] green;
    logic [DW-1:0] blue;
    logic [DW-1:0] alpha;
  } pixel_rgba_t;

  typedef struct packed {
    logic          full;
    logic          pinned;
    logic [DW-1:0] luma;
    logic [DW-1:0] cb;
    logic [DW-1:0] cr;
    logic [DW-1:0] red;
    logic [DW-1:0] green;
    logic [DW-1:0] blue;
  } pixel_case_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MASK} ready_style_t;

  logic          clk         = 1'b0;
  logic          rst         = 1'b1;
  logic          cfg_we      = 1'b0;
  logic          cfg_data    = 1'b0;
  logic          in_valid    = 1'b0;
  logic          in_ready;
  logic [DW-1:0] luma        = '0;
  logic [DW-1:0] chroma_blue = '0;
  logic [DW-1:0] chroma_red  = '0;
  logic          out_valid;
  logic          out_ready   = 1'b0;
  logic [DW-1:0] red;
  logic [DW-1:0] green;
  logic [DW-1:0] blue;
  logic [DW-1:0] alpha;

  // mirror of the range register as the block holds it
  logic        range_full = 1'b1;
  // a typed-in result overrides the predictor for the word being offered
  logic        pin_valid  = 1'b0;
  pixel_rgba_t pin_value  = '0;

  pixel_rgba_t rgba_due_q[$];
  pixel_rgba_t rgba_want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  ready_style_t ready_style   = READY_ALWAYS;
  logic [7:0]   ready_mask    = 8'hff;
  int unsigned  style_left    = 0;

  // full, pinned, luma, cb, cr, then red, green, blue where pinned
  pixel_case_t directed_cases [CASE_COUNT] = '{
    '{1'b1, 1'b1, 8'd0,   8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b1, 8'd255, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},
    '{1'b1, 1'b1, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128},
    '{1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd128, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd128, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd85,  8'd170, 8'd85,  8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd170, 8'd85,  8'd170, 8'd0,   8'd0,   8'd0  },
    // limited range: luma clamped to black and white level
    '{1'b0, 1'b1, 8'd0,   8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b1, 8'd15,  8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b1, 8'd16,  8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b1, 8'd235, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},
    '{1'b0, 1'b1, 8'd236, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},
    '{1'b0, 1'b1, 8'd255, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},
    '{1'b0, 1'b0, 8'd126, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b0, 8'd235, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b0, 8'd16,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b0, 8'd128, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b0, 8'd128, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0  },
    '{1'b0, 1'b0, 8'd128, 8'd64,  8'd192, 8'd0,   8'd0,   8'd0  },
    '{1'b1, 1'b0, 8'd1,   8'd127, 8'd129, 8'd0,   8'd0,   8'd0  }
  };

  ycbcr_to_rgba_bt601 #(
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha)
  );

  always #6 clk = ~clk;

  // num/den scaled to the fixed-point grid, rounded half up
  function automatic longint ratio_fx(longint unsigned num, longint unsigned den);
    return longint'(((num << FRAC) + den / 2) / den);
  endfunction

  function automatic logic [DW-1:0] clip_channel(longint sum);
    if (sum <= 0) return '0;
    if (sum >= longint'(yrgb_pkg::CHAN_MAX) * ONE_FX) return yrgb_pkg::CHAN_MAX;
    return DW'((sum + HALF_FX) >>> FRAC);
  endfunction

  function automatic pixel_rgba_t bt601_to_rgba(logic [DW-1:0] y, logic [DW-1:0] cb,
                                                logic [DW-1:0] cr, logic full);
    longint      ys, yc, u, v, kr, kgu, kgv, kb;
    pixel_rgba_t px;
    u = longint'(cb) - longint'(yrgb_pkg::CHROMA_OFFSET);
    v = longint'(cr) - longint'(yrgb_pkg::CHROMA_OFFSET);
    if (full) begin
      ys  = longint'(y) << FRAC;
      kr  = ratio_fx(yrgb_pkg::KR_NUM, yrgb_pkg::KR_DEN);
      kgu = ratio_fx(yrgb_pkg::KGU_NUM, yrgb_pkg::KGU_DEN);
      kgv = ratio_fx(yrgb_pkg::KGV_NUM, yrgb_pkg::KGV_DEN);
      kb  = ratio_fx(yrgb_pkg::KB_NUM, yrgb_pkg::KB_DEN);
    end else begin
      yc = longint'(y);
      if (yc < longint'(yrgb_pkg::LUMA_MIN)) yc = longint'(yrgb_pkg::LUMA_MIN);
      if (yc > longint'(yrgb_pkg::LUMA_MAX)) yc = longint'(yrgb_pkg::LUMA_MAX);
      ys  = ratio_fx(longint'(yc - longint'(yrgb_pkg::LUMA_MIN))
                     * longint'(yrgb_pkg::FULL_SPAN),
                     longint'(yrgb_pkg::LUMA_SPAN));
      kr  = ratio_fx(yrgb_pkg::KR_NUM * yrgb_pkg::FULL_SPAN,
                     yrgb_pkg::KR_DEN * yrgb_pkg::CHROMA_SPAN);
      kgu = ratio_fx(yrgb_pkg::KGU_NUM * yrgb_pkg::FULL_SPAN,
                     yrgb_pkg::KGU_DEN * yrgb_pkg::CHROMA_SPAN);
      kgv = ratio_fx(yrgb_pkg::KGV_NUM * yrgb_pkg::FULL_SPAN,
                     yrgb_pkg::KGV_DEN * yrgb_pkg::CHROMA_SPAN);
      kb  = ratio_fx(yrgb_pkg::KB_NUM * yrgb_pkg::FULL_SPAN,
                     yrgb_pkg::KB_DEN * yrgb_pkg::CHROMA_SPAN);
    end
    px.red   = clip_channel(ys + kr * v);
    px.green = clip_channel(ys - kgu * u - kgv * v);
    px.blue  = clip_channel(ys + kb * u);
    px.alpha = yrgb_pkg::ALPHA_OPAQUE;
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // pixel and word bookkeeping; values read here are the ones from before the edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("timed out with %0d words outstanding", rgba_due_q.size());
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (pin_valid) rgba_due_q.push_back(pin_value);
        else rgba_due_q.push_back(bt601_to_rgba(luma, chroma_blue, chroma_red, range_full));
      end
      if (out_valid && out_ready) begin
        if (rgba_due_q.size() == 0) begin
          report_mismatch("word with no pixel pending", int'({red, green, blue}), -1);
        end else begin
          rgba_want = rgba_due_q.pop_front();
          if (red !== rgba_want.red)
            report_mismatch("red", int'(red), int'(rgba_want.red));
          if (green !== rgba_want.green)
            report_mismatch("green", int'(green), int'(rgba_want.green));
          if (blue !== rgba_want.blue)
            report_mismatch("blue", int'(blue), int'(rgba_want.blue));
          if (alpha !== rgba_want.alpha)
            report_mismatch("alpha", int'(alpha), int'(rgba_want.alpha));
        end
      end
    end
  end

  // receiver back-pressure, switching between stall styles every so often
  always @(negedge clk) begin
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      ready_mask  = 8'($urandom);
      style_left  = $urandom_range(20, 120);
    end
    style_left--;
    case (ready_style)
      READY_ALWAYS: out_ready = 1'b1;
      READY_HALF:   out_ready = 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
      default: begin
        out_ready  = ready_mask[0];
        ready_mask = {ready_mask[0], ready_mask[7:1]};
      end
    endcase
  end

  task automatic send_pixel(input logic [DW-1:0] y, input logic [DW-1:0] cb,
                            input logic [DW-1:0] cr, input logic pin,
                            input pixel_rgba_t pinned);
    @(negedge clk);
    in_valid    = 1'b1;
    luma        = y;
    chroma_blue = cb;
    chroma_red  = cr;
    pin_valid   = pin;
    pin_value   = pinned;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // stop sending and let every pixel in flight come out
  task automatic drain_pixels();
    @(negedge clk);
    in_valid = 1'b0;
    while (rgba_due_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_range(input logic full);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = full;
    @(negedge clk);
    cfg_we     = 1'b0;
    range_full = full;
  endtask

  task automatic pick_pixel(output logic [DW-1:0] y, output logic [DW-1:0] cb,
                            output logic [DW-1:0] cr);
    y  = DW'($urandom);
    cb = DW'($urandom);
    cr = DW'($urandom);
    case ($urandom_range(0, 9))
      0: y = $urandom_range(0, 1) ? DW'($urandom_range(0, 20)) : DW'($urandom_range(230, 255));
      1: begin
        cb = $urandom_range(0, 1) ? 8'd0 : 8'd255;
        cr = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      end
      2: begin
        cb = DW'($urandom_range(120, 136));
        cr = DW'($urandom_range(120, 136));
      end
      default: ;
    endcase
  endtask

  initial begin
    pixel_case_t   row;
    pixel_rgba_t   pinned;
    logic [DW-1:0] y, cb, cr;
    int unsigned   burst_left;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_range(1'b1);

    for (int i = 0; i < CASE_COUNT; i++) begin
      row = directed_cases[i];
      if (row.full != range_full) begin
        drain_pixels();
        set_range(row.full);
      end
      pinned = '{row.red, row.green, row.blue, yrgb_pkg::ALPHA_OPAQUE};
      send_pixel(row.luma, row.cb, row.cr, row.pinned, pinned);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pixels();
      // first random phase flips the range so both settings see random pixels
      if (phase == 0) set_range(~range_full);
      else set_range(1'($urandom_range(0, 1)));
      burst_left = $urandom_range(1, 32);
      for (int n = 0; n < PHASE_PIXS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 19) == 0) drain_pixels();
          else if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 10));
          burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        pick_pixel(y, cb, cr);
        send_pixel(y, cb, cr, 1'b0, '0);
      end
    end

    drain_pixels();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
